// ===== src/dda_pkg.sv =====
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants of the DDA line rasterizer: field widths,
// mode and register codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package dda_pkg;

  // field widths
  localparam int COORD_W  = 13;
  localparam int COLOR_W  = 24;
  localparam int OFFSET_W = 26;
  localparam int STRIDE_W = 16;
  localparam int BPP_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // steps count and pixel counter widths
  localparam int STEPS_W = COORD_W;
  localparam int LEFT_W  = COORD_W + 1;

  // screen-space coordinate as seen by the address math
  localparam int SCR_W = COORD_W - 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic [OFFSET_W-1:0]       offset_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

  // request modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // register indexes
  localparam cfg_idx_t REG_ROW_STRIDE      = 1'd0;
  localparam cfg_idx_t REG_BYTES_PER_PIXEL = 1'd1;

  // register reset values
  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST = 16'd4096;
  localparam logic [BPP_W-1:0]    BPP_RST        = 4'd4;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RND,
    ST_ADDR
  } dda_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic tick;
    logic out_load;
  } dda_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic line_active;
    logic div_last;
    logic out_free;
  } dda_sts_t;

endpackage

// ===== src/dda_if.sv =====
// ----------------------------------------------------------------------------
// dda_if
// Valid/ready channels of the DDA line rasterizer: line and tick requests,
// pixel results and register writes.
// ----------------------------------------------------------------------------

// line and tick requests
interface dda_in_if;
  import dda_pkg::*;
  logic   valid;
  logic   ready;
  logic   mode;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  color_t line_color;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink (input valid, mode, start_x, start_y, end_x, end_y, line_color,
                output ready);
endinterface

// pixel results
interface dda_out_if;
  import dda_pkg::*;
  logic    valid;
  logic    ready;
  coord_t  pixel_x;
  coord_t  pixel_y;
  color_t  pixel_color;
  logic    on_screen;
  offset_t byte_offset;
  logic    last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, on_screen, byte_offset,
                  last, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, on_screen, byte_offset,
                last, output ready);
endinterface

// register writes
interface dda_cfg_if;
  import dda_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: loads a line and steps out one pixel per tick with
// its screen flag and framebuffer byte offset.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : valid/ready requests; mode 0 loads a line (endpoints, color),
//            mode 1 is a tick that asks for the next pixel of the line.
//   out_ch : valid/ready pixel results, one per tick while a line is active;
//            a tick with no active line produces nothing.
//   cfg_ch : register writes (row stride, bytes per pixel), always ready;
//            write only while the block is idle.
// Timing
//   load : accepted, then the divider yields one quotient bit per cycle for
//          both axes; no further request is taken until it is done.
//   tick : accepted, the round stage registers the pixel, then the address
//          stage loads the result register once out_ch is free; only then is
//          the next request taken, so one tick finishes before the next.
// Reset: registers take stride 4096 and 4 bytes per pixel, no line active,
//   result channel empty.
// Stall: the finished pixel waits in the output register; the block accepts
//   the next request and holds the following pixel until out_ch frees up.
// ----------------------------------------------------------------------------
module dda_line_rasterizer
  import dda_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024,
  parameter int FRAC_BITS     = 16
) (
  input logic      clk,
  input logic      rst_n,
  dda_in_if.sink   in_ch,
  dda_out_if.source out_ch,
  dda_cfg_if.sink  cfg_ch
);

  dda_cmd_t cmd;
  dda_sts_t sts;

  // register port never stalls
  assign cfg_ch.ready = 1'b1;

  // controller
  dda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  dda_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .start_x     (in_ch.start_x),
    .start_y     (in_ch.start_y),
    .end_x       (in_ch.end_x),
    .end_y       (in_ch.end_y),
    .line_color  (in_ch.line_color),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .pixel_x     (out_ch.pixel_x),
    .pixel_y     (out_ch.pixel_y),
    .pixel_color (out_ch.pixel_color),
    .on_screen   (out_ch.on_screen),
    .byte_offset (out_ch.byte_offset),
    .last        (out_ch.last)
  );

  // no request taken while the divider runs
  a_no_req_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !in_ch.ready)
    else $error("request accepted during divide");

  // last divider step makes the line active
  a_div_activates: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && sts.div_last) |=> sts.line_active)
    else $error("line not active after divide");

  // pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // tick with no line makes no pixel
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.mode == MODE_TICK) && !sts.line_active)
      |=> !cmd.tick)
    else $error("pixel produced with no active line");

endmodule

// ===== src/dda_ctrl.sv =====
// ----------------------------------------------------------------------------
// dda_ctrl
// Controller of the DDA line rasterizer: takes requests, runs the increment
// divider on a load and sequences rounding and addressing on a tick.
// ----------------------------------------------------------------------------
module dda_ctrl
  import dda_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_mode,
  output logic     in_ready,
  input  dda_sts_t sts,
  output dda_cmd_t cmd
);

  dda_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            state_nxt = ST_DIV;
          end else if (sts.line_active) begin
            state_nxt = ST_RND;
          end
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RND: begin
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid && (in_mode == MODE_LOAD);
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_RND: begin
        cmd.tick = 1'b1;
      end
      ST_ADDR: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/dda_dp.sv =====
// ----------------------------------------------------------------------------
// dda_dp
// Datapath of the DDA line rasterizer: configuration registers, line state,
// a two-lane restoring divider for the increments, position rounding and the
// framebuffer address multiply feeding the result register.
// ----------------------------------------------------------------------------
module dda_dp
  import dda_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024,
  parameter int FRAC_BITS     = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dda_cmd_t  cmd,
  output dda_sts_t  sts,
  // request payload
  input  coord_t    start_x,
  input  coord_t    start_y,
  input  coord_t    end_x,
  input  coord_t    end_y,
  input  color_t    line_color,
  // register writes
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  cfg_data_t cfg_data,
  // result register
  output logic      out_valid,
  input  logic      out_ready,
  output coord_t    pixel_x,
  output coord_t    pixel_y,
  output color_t    pixel_color,
  output logic      on_screen,
  output offset_t   byte_offset,
  output logic      last
);

  localparam int POS_W  = FRAC_BITS + COORD_W + 1;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int RND_W  = POS_W - FRAC_BITS;
  localparam int REM_W  = STEPS_W + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);
  localparam logic [POS_W-1:0] HALF     = POS_W'(1) << (FRAC_BITS - 1);
  localparam logic [COORD_W-1:0] SCR_W_LIM = COORD_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0] SCR_H_LIM = COORD_W'(SCREEN_HEIGHT);

  // configuration
  logic [STRIDE_W-1:0] stride_r;
  logic [BPP_W-1:0]    bpp_r;

  // line state
  logic                     active_r;
  logic signed [POS_W-1:0]  pos_x_r, pos_y_r;
  logic signed [STEP_W-1:0] step_x_r, step_y_r;
  logic [LEFT_W-1:0]        left_r;
  color_t                   color_r;

  // divider state
  logic [REM_W-1:0]   rem_x_r, rem_y_r;
  logic [Q_W-1:0]     q_x_r, q_y_r;
  logic [STEPS_W-1:0] steps_r;
  logic               neg_x_r, neg_y_r, zero_r;
  logic [CNT_W-1:0]   cnt_r;

  // rounded pixel
  coord_t x_r, y_r;
  logic   vis_r, last_px_r;

  // result register
  logic    out_valid_r;
  coord_t  out_x_r, out_y_r;
  color_t  out_color_r;
  logic    out_vis_r, out_last_r;
  offset_t out_off_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= ROW_STRIDE_RST;
      bpp_r    <= BPP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_STRIDE:      stride_r <= cfg_data;
        REG_BYTES_PER_PIXEL: bpp_r    <= cfg_data[BPP_W-1:0];
        default:             stride_r <= stride_r;
      endcase
    end
  end

  // line setup: deltas, magnitudes and step count
  logic signed [COORD_W:0] dx, dy;
  logic [STEPS_W-1:0]      adx, ady, steps;

  always_comb begin
    dx    = (COORD_W+1)'(end_x) - (COORD_W+1)'(start_x);
    dy    = (COORD_W+1)'(end_y) - (COORD_W+1)'(start_y);
    adx   = dx[COORD_W] ? STEPS_W'(-dx) : STEPS_W'(dx);
    ady   = dy[COORD_W] ? STEPS_W'(-dy) : STEPS_W'(dy);
    steps = (adx > ady) ? adx : ady;
  end

  // one quotient bit per lane and cycle
  logic [REM_W-1:0]  ge_x_rem, ge_y_rem, rem_x_nxt, rem_y_nxt;
  logic              bit_x, bit_y;
  logic [Q_W-1:0]    q_x_nxt, q_y_nxt;
  logic [STEP_W-1:0] qx_ext, qy_ext, step_x_nxt, step_y_nxt;

  always_comb begin
    bit_x     = rem_x_r >= REM_W'(steps_r);
    bit_y     = rem_y_r >= REM_W'(steps_r);
    ge_x_rem  = bit_x ? (rem_x_r - REM_W'(steps_r)) : rem_x_r;
    ge_y_rem  = bit_y ? (rem_y_r - REM_W'(steps_r)) : rem_y_r;
    rem_x_nxt = ge_x_rem << 1;
    rem_y_nxt = ge_y_rem << 1;
    q_x_nxt   = {q_x_r[Q_W-2:0], bit_x};
    q_y_nxt   = {q_y_r[Q_W-2:0], bit_y};
    qx_ext    = STEP_W'(q_x_nxt);
    qy_ext    = STEP_W'(q_y_nxt);
    // zero-length line keeps both increments at zero
    step_x_nxt = zero_r ? '0 : (neg_x_r ? -qx_ext : qx_ext);
    step_y_nxt = zero_r ? '0 : (neg_y_r ? -qy_ext : qy_ext);
  end

  // round half away from zero
  logic [POS_W-1:0] mag_x, mag_y, sum_x, sum_y;
  logic [RND_W-1:0] rx, ry, cx, cy;
  logic             vis_nxt;

  always_comb begin
    mag_x   = pos_x_r[POS_W-1] ? POS_W'(-pos_x_r) : POS_W'(pos_x_r);
    mag_y   = pos_y_r[POS_W-1] ? POS_W'(-pos_y_r) : POS_W'(pos_y_r);
    sum_x   = mag_x + HALF;
    sum_y   = mag_y + HALF;
    rx      = sum_x[POS_W-1:FRAC_BITS];
    ry      = sum_y[POS_W-1:FRAC_BITS];
    cx      = pos_x_r[POS_W-1] ? -rx : rx;
    cy      = pos_y_r[POS_W-1] ? -ry : ry;
    vis_nxt = !cx[RND_W-1] && (cx[COORD_W-1:0] < SCR_W_LIM)
           && !cy[RND_W-1] && (cy[COORD_W-1:0] < SCR_H_LIM);
  end

  // line state, divider and rounding registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      step_x_r <= '0;
      step_y_r <= '0;
      left_r   <= '0;
      color_r  <= '0;
      cnt_r    <= '0;
    end else begin
      if (cmd.load) begin
        active_r <= 1'b0;
        pos_x_r  <= POS_W'(start_x) <<< FRAC_BITS;
        pos_y_r  <= POS_W'(start_y) <<< FRAC_BITS;
        left_r   <= LEFT_W'(steps) + LEFT_W'(1);
        color_r  <= line_color;
        cnt_r    <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          step_x_r <= step_x_nxt;
          step_y_r <= step_y_nxt;
          active_r <= 1'b1;
        end
      end else if (cmd.tick) begin
        pos_x_r <= pos_x_r + POS_W'(step_x_r);
        pos_y_r <= pos_y_r + POS_W'(step_y_r);
        left_r  <= left_r - LEFT_W'(1);
        if (left_r <= LEFT_W'(1)) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  // divider and rounded pixel payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_x_r <= REM_W'(adx);
      rem_y_r <= REM_W'(ady);
      q_x_r   <= '0;
      q_y_r   <= '0;
      steps_r <= steps;
      neg_x_r <= dx[COORD_W];
      neg_y_r <= dy[COORD_W];
      zero_r  <= (steps == '0);
    end else if (cmd.div_step) begin
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      q_x_r   <= q_x_nxt;
      q_y_r   <= q_y_nxt;
    end
    if (cmd.tick) begin
      x_r       <= cx[COORD_W-1:0];
      y_r       <= cy[COORD_W-1:0];
      vis_r     <= vis_nxt;
      last_px_r <= (left_r <= LEFT_W'(1));
    end
  end

  // framebuffer offset
  logic [STRIDE_W+SCR_W-1:0] prod_y;
  logic [BPP_W+SCR_W-1:0]    prod_x;
  logic [STRIDE_W+SCR_W-1:0] off_sum;

  always_comb begin
    prod_y  = (STRIDE_W+SCR_W)'(y_r[SCR_W-1:0]) * (STRIDE_W+SCR_W)'(stride_r);
    prod_x  = (BPP_W+SCR_W)'(x_r[SCR_W-1:0]) * (BPP_W+SCR_W)'(bpp_r);
    off_sum = prod_y + (STRIDE_W+SCR_W)'(prod_x);
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x_r     <= x_r;
      out_y_r     <= y_r;
      out_color_r <= color_r;
      out_vis_r   <= vis_r;
      out_last_r  <= last_px_r;
      out_off_r   <= vis_r ? off_sum[OFFSET_W-1:0] : '0;
    end
  end

  assign sts.line_active = active_r;
  assign sts.div_last    = (cnt_r == CNT_LAST);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign pixel_x     = out_x_r;
  assign pixel_y     = out_y_r;
  assign pixel_color = out_color_r;
  assign on_screen   = out_vis_r;
  assign byte_offset = out_off_r;
  assign last        = out_last_r;

endmodule
